### src/fee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fee_pkg - shared types and constants
// Field widths, code points and the controller state type for the flash
// EEPROM emulator.
// ----------------------------------------------------------------------------
package fee_pkg;

    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;

    localparam logic [DATA_W-1:0] C_EMPTY = 8'hFF;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FIND,
        S_READ,
        S_READ_WAIT,
        S_COPY,
        S_OVERLAY,
        S_SEARCH,
        S_PROG,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### src/flash_eeprom_emulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_eeprom_emulator - byte EEPROM emulated over flash pages
// Page store, run buffer and page owner table with a sequential controller.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the result
// appears for one cycle on o_valid (the receiver cannot stall it). A read goes
// through bank split, owner scan and flash read. A write that opens a run
// copies the page into the run buffer; a commit searches for an empty page
// and, if it finds one, programs it from the buffer. Both sweeps go one byte
// per cycle, the copy through the flash read port and the programming through
// its write port. An out-of-range address goes straight to the result.
// The flash array needs no clearing after reset: a page is only read while it
// is owned, and every owned page was fully programmed.
module flash_eeprom_emulator import fee_pkg::*; #(
    parameter int PAGE_BYTES = 256,
    parameter int NUM_BANKS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic              i_last_byte,
    output logic                   o_valid,
    output logic      [DATA_W-1:0] o_read_data,
    output logic                   o_status,
    output logic                   o_committed
);

    localparam int DATA_BYTES = PAGE_BYTES - 1;
    localparam int LBANKS     = NUM_BANKS / 2;
    localparam int CAPACITY   = LBANKS * DATA_BYTES;
    localparam int PW         = $clog2(NUM_BANKS);
    localparam int BW         = (LBANKS > 1) ? $clog2(LBANKS) : 1;
    localparam int OW         = $clog2(DATA_BYTES);
    localparam int FDEPTH     = NUM_BANKS * PAGE_BYTES;
    localparam int FW         = $clog2(FDEPTH);
    localparam int MAXN       = (PAGE_BYTES > NUM_BANKS) ? PAGE_BYTES : NUM_BANKS;
    localparam int CW         = $clog2(MAXN + 1);

    function automatic logic [FW-1:0] f_faddr(input logic [PW-1:0] p,
                                              input logic [FW-1:0] b);
        return FW'(p) * FW'(PAGE_BYTES) + b;
    endfunction

    t_state r_state, n_state;

    logic              r_action, n_action;
    logic [DATA_W-1:0] r_wdata, n_wdata;
    logic              r_last, n_last;
    logic [BW-1:0]     r_bank, n_bank;
    logic [OW-1:0]     r_off, n_off;
    logic              r_hit, n_hit;
    logic [PW-1:0]     r_page, n_page;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [PW-1:0]     r_scan, n_scan;
    logic [PW-1:0]     r_next, n_next;
    logic              r_pend_valid, n_pend_valid;
    logic [BW-1:0]     r_pend_bank, n_pend_bank;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic              r_status, n_status;
    logic              r_committed, n_committed;
    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_owner [NUM_BANKS];

    logic              accept, in_range;
    logic              div_start, div_done;
    logic [BW-1:0]     div_quot;
    logic [OW-1:0]     div_rem;
    logic              match, hit_now, find_last, same_run, commit_now;
    logic              empty_now, search_last, cnt_at_data;
    logic [PW-1:0]     scan_inc;
    logic              own_set, own_clr;

    logic              fl_we, fl_re;
    logic [FW-1:0]     fl_waddr, fl_raddr;
    logic [DATA_W-1:0] fl_wdata, fl_q;
    logic              bf_we, bf_re;
    logic [OW-1:0]     bf_waddr, bf_raddr;
    logic [DATA_W-1:0] bf_wdata, bf_q;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign in_range    = (32'(i_address) < 32'(CAPACITY));
    assign match       = (r_owner[r_cnt[PW-1:0]] == DATA_W'(r_bank));
    assign hit_now     = r_hit || match;
    assign find_last   = (r_cnt == CW'(NUM_BANKS - 1));
    assign same_run    = r_pend_valid && (r_pend_bank == r_bank);
    assign commit_now  = r_last || (r_off == OW'(DATA_BYTES - 1));
    assign empty_now   = (r_owner[r_scan] == C_EMPTY);
    assign search_last = (r_cnt == CW'(NUM_BANKS - 1));
    assign cnt_at_data = (r_cnt == CW'(DATA_BYTES));
    assign scan_inc    = (r_scan == PW'(NUM_BANKS - 1)) ? '0 : r_scan + PW'(1);

    fee_div #(
        .DIVISOR (DATA_BYTES),
        .QW      (BW),
        .RW      (OW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_address),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    fee_ram #(
        .W     (DATA_W),
        .DEPTH (FDEPTH),
        .AW    (FW)
    ) u_flash (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_re    (fl_re),
        .i_raddr (fl_raddr),
        .o_rdata (fl_q)
    );

    fee_ram #(
        .W     (DATA_W),
        .DEPTH (DATA_BYTES),
        .AW    (OW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (bf_we),
        .i_waddr (bf_waddr),
        .i_wdata (bf_wdata),
        .i_re    (bf_re),
        .i_raddr (bf_raddr),
        .o_rdata (bf_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = in_range ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (find_last) begin
                    if (r_action == ACT_READ) begin
                        n_state = hit_now ? S_READ : S_DONE;
                    end else begin
                        n_state = same_run ? S_OVERLAY : S_COPY;
                    end
                end
            end
            S_READ:      n_state = S_READ_WAIT;
            S_READ_WAIT: n_state = S_DONE;
            S_COPY: begin
                if (cnt_at_data) begin
                    n_state = S_OVERLAY;
                end
            end
            S_OVERLAY:   n_state = commit_now ? S_SEARCH : S_DONE;
            S_SEARCH: begin
                if (empty_now) begin
                    n_state = S_PROG;
                end else if (search_last) begin
                    n_state = S_DONE;
                end
            end
            S_PROG: begin
                if (cnt_at_data) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_action     = r_action;
        n_wdata      = r_wdata;
        n_last       = r_last;
        n_bank       = r_bank;
        n_off        = r_off;
        n_hit        = r_hit;
        n_page       = r_page;
        n_cnt        = r_cnt;
        n_scan       = r_scan;
        n_next       = r_next;
        n_pend_valid = r_pend_valid;
        n_pend_bank  = r_pend_bank;
        n_rdata      = r_rdata;
        n_status     = r_status;
        n_committed  = r_committed;
        n_valid      = 1'b0;
        div_start    = 1'b0;
        own_set      = 1'b0;
        own_clr      = 1'b0;
        fl_we        = 1'b0;
        fl_waddr     = '0;
        fl_wdata     = '0;
        fl_re        = 1'b0;
        fl_raddr     = '0;
        bf_we        = 1'b0;
        bf_waddr     = '0;
        bf_wdata     = '0;
        bf_re        = 1'b0;
        bf_raddr     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action    = i_action;
                    n_wdata     = i_write_data;
                    n_last      = i_last_byte;
                    n_rdata     = '0;
                    n_committed = 1'b0;
                    if (in_range) begin
                        n_status  = ST_OK;
                        div_start = 1'b1;
                    end else begin
                        n_status     = ST_RANGE;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_bank = div_quot;
                    n_off  = div_rem;
                    n_hit  = 1'b0;
                    n_cnt  = '0;
                end
            end
            S_FIND: begin
                n_cnt = r_cnt + CW'(1);
                if (match) begin
                    n_hit  = 1'b1;
                    n_page = r_cnt[PW-1:0];
                end
                if (find_last) begin
                    n_cnt = '0;
                    if (r_action == ACT_READ && !hit_now) begin
                        n_rdata = C_EMPTY;
                    end
                end
            end
            S_READ: begin
                fl_re    = 1'b1;
                fl_raddr = f_faddr(r_page, FW'(r_off) + FW'(1));
            end
            S_READ_WAIT: begin
                n_rdata = fl_q;
            end
            S_COPY: begin
                n_cnt = r_cnt + CW'(1);
                if (!cnt_at_data) begin
                    fl_re    = r_hit;
                    fl_raddr = f_faddr(r_page, FW'(r_cnt) + FW'(1));
                end
                if (r_cnt != '0) begin
                    bf_we    = 1'b1;
                    bf_waddr = OW'(r_cnt - CW'(1));
                    bf_wdata = r_hit ? fl_q : C_EMPTY;
                end
                if (cnt_at_data) begin
                    n_pend_valid = 1'b1;
                    n_pend_bank  = r_bank;
                end
            end
            S_OVERLAY: begin
                bf_we    = 1'b1;
                bf_waddr = r_off;
                bf_wdata = r_wdata;
                if (commit_now) begin
                    n_scan = r_next;
                    n_cnt  = '0;
                end
            end
            S_SEARCH: begin
                if (empty_now) begin
                    n_next   = r_scan;
                    own_set  = 1'b1;
                    own_clr  = r_hit;
                    fl_we    = 1'b1;
                    fl_waddr = f_faddr(r_scan, '0);
                    fl_wdata = DATA_W'(r_bank);
                    n_cnt    = '0;
                end else begin
                    n_scan = scan_inc;
                    n_cnt  = r_cnt + CW'(1);
                    if (search_last) begin
                        n_pend_valid = 1'b0;
                    end
                end
            end
            S_PROG: begin
                n_cnt = r_cnt + CW'(1);
                if (!cnt_at_data) begin
                    bf_re    = 1'b1;
                    bf_raddr = OW'(r_cnt);
                end
                if (r_cnt != '0) begin
                    fl_we    = 1'b1;
                    fl_waddr = f_faddr(r_scan, FW'(r_cnt));
                    fl_wdata = bf_q;
                end
                if (cnt_at_data) begin
                    n_committed  = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next       <= '0;
            r_pend_valid <= 1'b0;
            r_pend_bank  <= '0;
            r_valid      <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_owner[i] <= C_EMPTY;
            end
        end else begin
            r_state      <= n_state;
            r_next       <= n_next;
            r_pend_valid <= n_pend_valid;
            r_pend_bank  <= n_pend_bank;
            r_valid      <= n_valid;
            if (own_clr) begin
                r_owner[r_page] <= C_EMPTY;
            end
            if (own_set) begin
                r_owner[r_scan] <= DATA_W'(r_bank);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_wdata     <= n_wdata;
        r_last      <= n_last;
        r_bank      <= n_bank;
        r_off       <= n_off;
        r_hit       <= n_hit;
        r_page      <= n_page;
        r_cnt       <= n_cnt;
        r_scan      <= n_scan;
        r_rdata     <= n_rdata;
        r_status    <= n_status;
        r_committed <= n_committed;
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_rdata;
    assign o_status    = r_status;
    assign o_committed = r_committed;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANGE) |-> (!o_committed && o_read_data == '0))
        else $error("out-of-range result carries data or commit");

    a_commit_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_committed) |-> !r_pend_valid)
        else $error("run still pending after commit");

    a_prog_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROG) |-> (r_owner[r_scan] == DATA_W'(r_bank)))
        else $error("programmed page not owned by committing bank");

endmodule
`default_nettype wire

### src/fee_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fee_ram - simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fee_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/fee_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fee_div - address to bank/offset split
// Repeated subtraction of the bank size, one step per cycle.
// ----------------------------------------------------------------------------
module fee_div import fee_pkg::*; #(
    parameter int DIVISOR = 255,
    parameter int QW      = 2,
    parameter int RW      = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_dividend,
    output logic                   o_done,
    output logic      [QW-1:0]     o_quot,
    output logic      [RW-1:0]     o_rem
);

    logic              r_busy;
    logic [ADDR_W-1:0] r_rem;
    logic [QW-1:0]     r_quot;
    logic              ge;

    assign ge = (r_rem >= ADDR_W'(DIVISOR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !ge) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_quot <= '0;
        end else if (r_busy && ge) begin
            r_rem  <= r_rem - ADDR_W'(DIVISOR);
            r_quot <= r_quot + QW'(1);
        end
    end

    assign o_done = r_busy && !ge;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[RW-1:0];

endmodule
`default_nettype wire
